@@ design/ics_pkg.sv @@
package ics_pkg;

  // Fixed field widths of the stream and configuration words
  localparam int PIX_W       = 8;
  localparam int IDX_W       = 12;
  localparam int SUM_W       = 24;
  localparam int WIDTH_W     = 13;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Default line store depth
  localparam int MAX_WIDTH_DEF = 4096;

  // Output queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRADIENT_MODE,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } ics_reg_t;

  // Per-pixel control flags handed from the front end to the accumulator
  typedef struct packed {
    logic acc;    // pixel updates a line store entry
    logic first;  // first row: entry is overwritten, not added to
    logic r0;     // emit the accumulated column
    logic r1;     // emit the trailing zero column (gradient mode)
    logic last0;  // accumulated column closes the frame
  } ics_ctl_t;

  // One finished column result
  typedef struct packed {
    logic             last;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] idx;
  } ics_result_t;

endpackage

@@ design/ics_front.sv @@
module ics_front #(
  parameter int MAX_WIDTH = ics_pkg::MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [ics_pkg::PIX_W-1:0]     pixel,
  input  logic                          gradient_mode,
  input  logic [ics_pkg::WIDTH_W-1:0]   image_width,
  input  logic [ics_pkg::HEIGHT_W-1:0]  image_height,
  output ics_pkg::ics_ctl_t             ctl,
  output logic [COL_W-1:0]              addr,
  output logic [COL_W-1:0]              col,
  output logic [ics_pkg::PIX_W-1:0]     value
);
  import ics_pkg::*;

  logic [COL_W-1:0]    column_position;
  logic [HEIGHT_W-1:0] row_position;
  logic [PIX_W-1:0]    previous_pixel;

  logic [31:0]         width_ext;
  logic [COL_W-1:0]    last_idx;
  logic [HEIGHT_W-1:0] last_row;
  logic                last_col;
  logic                final_row;
  logic [PIX_W-1:0]    diff;

  // Index of the last column, with zero taken as one and large widths saturated
  assign width_ext = 32'(image_width);
  always_comb begin
    if (width_ext == 32'd0) begin
      last_idx = '0;
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      last_idx = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_idx = COL_W'(width_ext - 32'd1);
    end
  end

  assign last_row  = (image_height == '0) ? '0 : image_height - 1'b1;
  assign last_col  = column_position >= last_idx;
  assign final_row = row_position >= last_row;
  assign col       = last_col ? last_idx : column_position;

  // Absolute horizontal difference against the previous pixel
  assign diff = (pixel > previous_pixel) ? pixel - previous_pixel
                                         : previous_pixel - pixel;

  // Store address, added value and the results this pixel produces
  always_comb begin
    ctl = '0;
    ctl.first = (row_position == '0);
    if (gradient_mode) begin
      ctl.acc   = (col != '0);
      addr      = col - 1'b1;
      value     = diff;
      ctl.r0    = final_row && (col != '0);
      ctl.r1    = final_row && last_col;
      ctl.last0 = 1'b0;
    end else begin
      ctl.acc   = 1'b1;
      addr      = col;
      value     = pixel;
      ctl.r0    = final_row;
      ctl.r1    = 1'b0;
      ctl.last0 = last_col;
    end
  end

  // Raster position and previous pixel advance on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      previous_pixel  <= '0;
    end else if (accept) begin
      previous_pixel <= pixel;
      if (last_col) begin
        column_position <= '0;
        row_position    <= final_row ? '0 : row_position + 1'b1;
      end else begin
        column_position <= col + 1'b1;
      end
    end
  end

endmodule

@@ design/ics_accum.sv @@
module ics_accum #(
  parameter int MAX_WIDTH = ics_pkg::MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  ics_pkg::ics_ctl_t         ctl,
  input  logic [COL_W-1:0]          addr,
  input  logic [COL_W-1:0]          col,
  input  logic [ics_pkg::PIX_W-1:0] value,
  output logic                      push0,
  output ics_pkg::ics_result_t      res0,
  output logic                      push1,
  output ics_pkg::ics_result_t      res1,
  output logic [1:0]                pending
);
  import ics_pkg::*;

  logic [SUM_W-1:0] mem [MAX_WIDTH];
  logic [SUM_W-1:0] rdata;
  logic             byp_hit;
  logic [SUM_W-1:0] byp_data;

  logic             s1_valid;
  ics_ctl_t         s1_ctl;
  logic [COL_W-1:0] s1_addr;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_value;

  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum;
  logic             s1_write;

  // Read-modify-write: the entry written this cycle is forwarded to a new read
  assign base     = s1_ctl.first ? '0 : (byp_hit ? byp_data : rdata);
  assign sum      = base + SUM_W'(s1_value);
  assign s1_write = s1_valid && s1_ctl.acc;

  // Line store with registered read
  always_ff @(posedge clk) begin
    if (s1_write) begin
      mem[s1_addr] <= sum;
    end
    if (accept) begin
      rdata <= mem[addr];
    end
  end

  // Forwarding register and accumulate stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_hit  <= s1_write && (s1_addr == addr);
      byp_data <= sum;
      s1_ctl   <= ctl;
      s1_addr  <= addr;
      s1_col   <= col;
      s1_value <= value;
    end
  end

  // Stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Results handed to the output queue
  assign push0      = s1_valid && s1_ctl.r0;
  assign push1      = s1_valid && s1_ctl.r1;
  assign res0.idx   = IDX_W'(s1_addr);
  assign res0.sum   = sum;
  assign res0.last  = s1_ctl.last0;
  assign res1.idx   = IDX_W'(s1_col);
  assign res1.sum   = '0;
  assign res1.last  = 1'b1;
  assign pending    = {1'b0, push0} + {1'b0, push1};

endmodule

@@ design/ics_out_fifo.sv @@
module ics_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push0,
  input  ics_pkg::ics_result_t           res0,
  input  logic                           push1,
  input  ics_pkg::ics_result_t           res1,
  input  logic                           pop,
  output ics_pkg::ics_result_t           head,
  output logic [ics_pkg::LEVEL_W-1:0]    level
);
  import ics_pkg::*;

  ics_result_t           slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [LEVEL_W-1:0]    push_n;

  assign push_n = LEVEL_W'(push0) + LEVEL_W'(push1);
  assign head   = slots[rd_ptr];

  // Up to two results enter per cycle, the earlier one first
  always_ff @(posedge clk) begin
    if (push0 || push1) begin
      slots[wr_ptr] <= push0 ? res0 : res1;
    end
    if (push0 && push1) begin
      slots[wr_ptr + 1'b1] <= res1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      level  <= level + push_n - LEVEL_W'(pop);
    end
  end

endmodule

@@ design/image_column_sum_accumulator.sv @@
// The pixel completing a result word is registered in the accumulate stage, and the word
// then in the result queue, whose head the master side offers. Throughput: one pixel per
// cycle while the queue has room, set by one line store read and one write per cycle and
// the eight-entry result queue; a pixel ending a gradient-mode frame yields two words.
// Reset clears raster position, previous pixel, pipeline and queue, and restores the
// configuration defaults; the line store is not cleared, the first row overwrites it.
module image_column_sum_accumulator #(
  parameter int MAX_WIDTH = ics_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Slave stream; tdata: pixel [7:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ics_pkg::PIX_W-1:0]          s_tdata,
  // Master stream; tdata: column_index [11:0], column_sum [35:12], zero [39:36]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ics_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ics_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ics_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ics_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                gradient_mode;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  logic                accept;
  ics_ctl_t            ctl;
  logic [COL_W-1:0]    addr;
  logic [COL_W-1:0]    col;
  logic [PIX_W-1:0]    value;

  logic                push0;
  logic                push1;
  ics_result_t         res0;
  ics_result_t         res1;
  logic [1:0]          pending;
  ics_result_t         head;
  logic [LEVEL_W-1:0]  level;
  logic                pop;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_mode <= 1'b0;
      image_width   <= WIDTH_W'(4096);
      image_height  <= HEIGHT_W'(1);
    end else if (cfg_valid) begin
      case (ics_reg_t'(cfg_index))
        REG_GRADIENT_MODE: gradient_mode <= cfg_data[0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept a pixel while the queue has room for everything in flight
  assign s_tready = ({1'b0, level} + (LEVEL_W+1)'(pending)) <= (LEVEL_W+1)'(FIFO_DEPTH - 2);
  assign accept   = s_tvalid && s_tready;

  ics_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .pixel         (s_tdata),
    .gradient_mode (gradient_mode),
    .image_width   (image_width),
    .image_height  (image_height),
    .ctl           (ctl),
    .addr          (addr),
    .col           (col),
    .value         (value)
  );

  ics_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .ctl     (ctl),
    .addr    (addr),
    .col     (col),
    .value   (value),
    .push0   (push0),
    .res0    (res0),
    .push1   (push1),
    .res1    (res1),
    .pending (pending)
  );

  ics_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .res0  (res0),
    .push1 (push1),
    .res1  (res1),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  // Master side driven from the queue head
  assign m_tvalid = (level != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = OUT_TDATA_W'({head.sum, head.idx});
  assign m_tlast  = head.last;

`ifndef ASSERT_OFF
  // The queue never holds more words than it has slots.
  assert property (@(posedge clk) disable iff (rst) level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // A result pushed into the queue leaves it non-empty on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (push0 || push1) |=> (level != '0))
    else $error("pushed result lost from queue");

  // Out of reset the queue is empty and a pixel can be taken.
  assert property (@(posedge clk) $past(rst) |-> (level == '0 && s_tready))
    else $error("queue or ready wrong after reset");
`endif

endmodule
